>>> src/twd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// twd_pkg
// Shared types, constants and helpers of the transfer low-speed watchdog.
// ============================================================================
package twd_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int BKT_AW     = $clog2(MAX_WINDOW);
    localparam int WIN_W      = BKT_AW + 1;
    localparam int SEC_W      = 27;
    localparam int MOD_W      = SEC_W + 1;
    localparam int MINT_W     = 20 + WIN_W;
    localparam int Q_DEPTH    = 2;

    localparam logic [SEC_W-1:0] NOT_STARTED   = '1;
    localparam logic [6:0]       TICKS_PER_SEC = 7'd100;
    localparam logic [31:0]      FINAL_GRACE   = 32'd400;
    // x / 100 == (x * RECIP) >> RECIP_SHIFT for any 32-bit x
    localparam logic [31:0]      RECIP         = 32'h51EB851F;
    localparam int               RECIP_SHIFT   = 37;

    // request commands
    localparam logic [2:0] CMD_SENT     = 3'd0;
    localparam logic [2:0] CMD_RECEIVED = 3'd1;
    localparam logic [2:0] CMD_UP_START = 3'd2;
    localparam logic [2:0] CMD_UP_DONE  = 3'd3;
    localparam logic [2:0] CMD_REDIRECT = 3'd4;
    localparam logic [2:0] CMD_DONE     = 3'd5;
    localparam logic [2:0] CMD_CHECK    = 3'd6;

    // job kinds after decode
    localparam logic [2:0] KIND_NOP      = 3'd0;
    localparam logic [2:0] KIND_SEND     = 3'd1;
    localparam logic [2:0] KIND_RECV     = 3'd2;
    localparam logic [2:0] KIND_UP_START = 3'd3;
    localparam logic [2:0] KIND_UP_DONE  = 3'd4;
    localparam logic [2:0] KIND_REDIRECT = 3'd5;
    localparam logic [2:0] KIND_DONE     = 3'd6;
    localparam logic [2:0] KIND_CHECK    = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_REPLY  = 2'd0;
    localparam logic [1:0] CFG_WINDOW = 2'd1;
    localparam logic [1:0] CFG_MIN    = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] now_ticks;
        logic [15:0] byte_count;
        logic        last_bytes;
    } t_req;

    typedef struct packed {
        logic        abort_transfer;
        logic        deadline_armed;
        logic [31:0] stall_deadline;
        logic        switched_to_reply;
        logic        sequence_error;
    } t_res;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now_ticks;
        logic [15:0] byte_count;
        logic        last_bytes;
        logic        has_bytes;
    } t_job;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sat_sub32(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? (a - b) : 32'd0;
    endfunction

endpackage

>>> src/twd_front.sv
`timescale 1ns / 1ps
// ============================================================================
// twd_front
// Accepts requests and decodes each command into a job for the queue.
// ============================================================================
module twd_front
    import twd_pkg::*;
(
    input  logic i_req_valid,
    input  t_req i_req,
    output logic o_req_stall,
    input  logic i_q_full,
    output logic o_push,
    output t_job o_job
);

    logic [2:0] kind;

    always_comb begin
        case (i_req.command)
            CMD_SENT:     kind = KIND_SEND;
            CMD_RECEIVED: kind = KIND_RECV;
            CMD_UP_START: kind = KIND_UP_START;
            CMD_UP_DONE:  kind = KIND_UP_DONE;
            CMD_REDIRECT: kind = KIND_REDIRECT;
            CMD_DONE:     kind = KIND_DONE;
            CMD_CHECK:    kind = KIND_CHECK;
            default:      kind = KIND_NOP;
        endcase
    end

    assign o_req_stall = i_q_full;
    assign o_push      = i_req_valid & ~i_q_full;

    always_comb begin
        o_job.kind       = kind;
        o_job.now_ticks  = i_req.now_ticks;
        o_job.byte_count = i_req.byte_count;
        o_job.last_bytes = i_req.last_bytes;
        o_job.has_bytes  = (i_req.byte_count != 16'd0);
    end

endmodule

>>> src/twd_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// twd_queue
// Short job queue between the decode front and the rate engine.
// ============================================================================
module twd_queue
    import twd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    localparam int Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    t_job             r_slot [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp;
    logic [Q_AW-1:0]  r_rp;
    logic [Q_AW:0]    r_cnt;

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
        return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule

>>> src/twd_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// twd_engine
// Executes jobs: phase bookkeeping, bucket walk, stall scan, result register.
// ============================================================================
module twd_engine
    import twd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  t_job        i_job,
    input  logic        i_q_empty,
    output logic        o_pop,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output t_res        o_res
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_MUL      = 4'd2;
    localparam logic [3:0] S_SEC      = 4'd3;
    localparam logic [3:0] S_SAME     = 4'd4;
    localparam logic [3:0] S_WALK_RD  = 4'd5;
    localparam logic [3:0] S_WALK_WR  = 4'd6;
    localparam logic [3:0] S_MOD      = 4'd7;
    localparam logic [3:0] S_CUR_RD   = 4'd8;
    localparam logic [3:0] S_CUR      = 4'd9;
    localparam logic [3:0] S_JUDGE    = 4'd10;
    localparam logic [3:0] S_SCAN_RD  = 4'd11;
    localparam logic [3:0] S_SCAN_CHK = 4'd12;
    localparam logic [3:0] S_FIN      = 4'd13;
    localparam logic [3:0] S_OUT      = 4'd14;

    localparam int IT_W = $clog2(MOD_W);

    logic [3:0]        r_state;
    t_job              r_job;
    logic              r_last;

    // configuration
    logic [15:0]       r_reply;
    logic [6:0]        r_win;
    logic [19:0]       r_min;

    // watchdog state
    logic              r_rate_on;
    logic [31:0]       r_start;
    logic [SEC_W-1:0]  r_prev;
    logic [SEC_W-1:0]  r_fos;
    logic [BKT_AW-1:0] r_cb;
    logic [31:0]       r_total;
    logic [31:0]       r_dl_time;
    logic              r_dl_on;
    logic              r_up_done;
    logic              r_redir;
    logic              r_nothing;
    logic              r_final;

    // work registers
    logic [63:0]       r_prod;
    logic [MINT_W-1:0] r_mint;
    logic [SEC_W-1:0]  r_p;
    logic [WIN_W-1:0]  r_n;
    logic [WIN_W-1:0]  r_k;
    logic [BKT_AW-1:0] r_b;
    logic [MOD_W-1:0]  r_mod_a;
    logic [WIN_W-1:0]  r_rem;
    logic [IT_W-1:0]   r_it;
    logic              r_mod_scan;
    logic [MOD_W-1:0]  r_d;
    logic [31:0]       r_tot;
    logic              r_abort;
    logic              r_switch;
    logic              r_seqerr;
    logic              r_out_valid;
    t_res              r_out;

    // bucket memory
    logic [31:0]       mem [MAX_WINDOW];
    logic [31:0]       r_rdata;
    logic              mem_re;
    logic [BKT_AW-1:0] mem_ra;
    logic              mem_we;
    logic [BKT_AW-1:0] mem_wa;
    logic [31:0]       mem_wd;

    logic [WIN_W-1:0]  weff;
    logic [SEC_W-1:0]  sec;
    logic [SEC_W-1:0]  gap;
    logic [SEC_W-1:0]  sec1;
    logic [SEC_W-1:0]  t0;
    logic [WIN_W:0]    rem_sh;
    logic [WIN_W-1:0]  rem_nxt;
    logic [31:0]       bytes32;
    logic [22:0]       reply_ticks;
    logic [34:0]       d_ticks;
    logic [31:0]       tot_nxt;
    logic [31:0]       cur_total;
    logic              total_low;
    logic              take_job;

    function automatic logic [BKT_AW-1:0] nb(input logic [BKT_AW-1:0] b,
                                             input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] b1;
        b1 = {1'b0, b} + 1'b1;
        return (b1 >= w) ? '0 : b1[BKT_AW-1:0];
    endfunction

    // dividend of "bucket reached x steps ahead of the current bucket"
    function automatic logic [MOD_W-1:0] ahead_arg(input logic [BKT_AW-1:0] cb,
                                                   input logic [MOD_W-1:0] x,
                                                   input logic [WIN_W-1:0] w);
        return ({1'b0, cb} < w) ? (MOD_W'(cb) + x) : (x - 1'b1);
    endfunction

    always_comb begin
        if (r_win == 7'd0) begin
            weff = WIN_W'(1);
        end else if (int'(r_win) > MAX_WINDOW) begin
            weff = WIN_W'(MAX_WINDOW);
        end else begin
            weff = WIN_W'(r_win);
        end
    end

    assign sec         = r_prod[RECIP_SHIFT +: SEC_W];
    assign gap         = sec - r_prev;
    assign sec1        = sec + 1'b1;
    assign t0          = (r_fos > sec1) ? r_fos : sec1;
    assign rem_sh      = {r_rem, r_mod_a[MOD_W-1]};
    assign rem_nxt     = (rem_sh >= {1'b0, weff}) ? WIN_W'(rem_sh - {1'b0, weff})
                                                  : rem_sh[WIN_W-1:0];
    assign bytes32     = {16'd0, r_job.byte_count};
    assign reply_ticks = r_reply * TICKS_PER_SEC;
    assign d_ticks     = r_d * TICKS_PER_SEC;
    assign tot_nxt     = sat_sub32(r_tot, r_rdata);
    assign cur_total   = sat_add32((sec >= r_fos) ? sat_sub32(r_total, r_rdata) : r_total,
                                   bytes32);
    assign total_low   = (r_total < 32'(r_mint));
    assign take_job    = (r_state == S_IDLE) && !i_q_empty && !r_out_valid;
    assign o_pop       = take_job;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        mem_re = 1'b0;
        mem_ra = r_cb;
        mem_we = 1'b0;
        mem_wa = r_cb;
        mem_wd = bytes32;
        case (r_state)
            S_SEC: begin
                if (sec == r_prev) begin
                    mem_re = 1'b1;
                end else if (r_prev == NOT_STARTED) begin
                    mem_we = 1'b1;
                    mem_wa = '0;
                end
            end
            S_SAME: begin
                mem_we = 1'b1;
                mem_wd = sat_add32(r_rdata, bytes32);
            end
            S_WALK_RD: begin
                mem_re = 1'b1;
                mem_ra = nb(r_b, weff);
            end
            S_WALK_WR: begin
                mem_we = 1'b1;
                mem_wa = r_b;
                mem_wd = '0;
            end
            S_CUR_RD: begin
                mem_re = 1'b1;
            end
            S_CUR: begin
                mem_we = 1'b1;
            end
            S_SCAN_RD: begin
                mem_re = 1'b1;
                mem_ra = r_b;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_reply     <= 16'd60;
            r_win       <= 7'd30;
            r_min       <= 20'd7000;
            r_rate_on   <= 1'b0;
            r_start     <= '0;
            r_prev      <= NOT_STARTED;
            r_fos       <= '0;
            r_cb        <= '0;
            r_total     <= '0;
            r_dl_time   <= '0;
            r_dl_on     <= 1'b0;
            r_up_done   <= 1'b0;
            r_redir     <= 1'b0;
            r_nothing   <= 1'b1;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REPLY:  r_reply <= i_cfg_data[15:0];
                    CFG_WINDOW: r_win   <= i_cfg_data[6:0];
                    CFG_MIN:    r_min   <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (r_out_valid && !i_res_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (take_job) begin
                        r_job    <= i_job;
                        r_abort  <= 1'b0;
                        r_switch <= 1'b0;
                        r_seqerr <= 1'b0;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_last  <= (r_job.kind == KIND_SEND) && r_job.last_bytes;
                    r_state <= S_OUT;
                    case (r_job.kind)
                        KIND_SEND: begin
                            if (!r_rate_on) begin
                                r_start   <= r_job.now_ticks;
                                r_rate_on <= 1'b1;
                                r_final   <= 1'b0;
                                r_prev    <= NOT_STARTED;
                                r_dl_on   <= 1'b0;
                            end
                            r_state <= S_MUL;
                        end
                        KIND_RECV: begin
                            if (r_nothing && r_job.has_bytes) begin
                                if (!r_up_done) begin
                                    r_up_done <= 1'b1;
                                    r_redir   <= 1'b0;
                                    r_dl_time <= r_job.now_ticks + 32'(reply_ticks);
                                end
                                r_nothing <= 1'b0;
                                r_start   <= r_job.now_ticks;
                                r_rate_on <= 1'b1;
                                r_final   <= 1'b0;
                                r_prev    <= NOT_STARTED;
                                r_dl_on   <= 1'b0;
                                r_state   <= S_MUL;
                            end else if (r_rate_on) begin
                                r_state <= S_MUL;
                            end
                        end
                        KIND_UP_START: begin
                            r_seqerr  <= r_up_done && !r_redir;
                            r_up_done <= 1'b0;
                            r_start   <= r_job.now_ticks;
                            r_rate_on <= 1'b1;
                            r_final   <= 1'b0;
                            r_prev    <= NOT_STARTED;
                            r_dl_on   <= 1'b0;
                        end
                        KIND_UP_DONE, KIND_CHECK: begin
                            if (!r_up_done &&
                                (r_job.kind == KIND_UP_DONE || r_final)) begin
                                r_up_done <= 1'b1;
                                r_redir   <= 1'b0;
                                r_rate_on <= 1'b0;
                                r_dl_time <= r_job.now_ticks + 32'(reply_ticks);
                                r_dl_on   <= 1'b1;
                                r_switch  <= (r_job.kind == KIND_CHECK);
                            end
                        end
                        KIND_REDIRECT: begin
                            r_redir <= 1'b1;
                        end
                        KIND_DONE: begin
                            r_rate_on <= 1'b0;
                            r_dl_on   <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                S_MUL: begin
                    r_prod  <= {32'd0, r_job.now_ticks - r_start} * {32'd0, RECIP};
                    r_mint  <= r_min * weff;
                    r_state <= S_SEC;
                end
                S_SEC: begin
                    r_final <= r_last;
                    if (sec == r_prev) begin
                        r_total <= sat_add32(r_total, bytes32);
                        r_state <= S_SAME;
                    end else if (r_prev == NOT_STARTED) begin
                        r_prev  <= sec;
                        r_cb    <= '0;
                        r_fos   <= sec + SEC_W'(weff);
                        r_total <= bytes32;
                        r_state <= S_OUT;
                    end else begin
                        r_prev     <= sec;
                        r_p        <= r_prev;
                        r_b        <= r_cb;
                        r_k        <= WIN_W'(1);
                        r_mod_a    <= ahead_arg(r_cb, MOD_W'(gap), weff);
                        r_rem      <= '0;
                        r_it       <= '0;
                        r_mod_scan <= 1'b0;
                        if (gap - 1'b1 == '0) begin
                            r_state <= S_MOD;
                        end else begin
                            r_n     <= ((gap - 1'b1) < SEC_W'(weff)) ?
                                       WIN_W'(gap - 1'b1) : weff;
                            r_state <= S_WALK_RD;
                        end
                    end
                end
                S_SAME: begin
                    r_state <= S_OUT;
                end
                S_WALK_RD: begin
                    r_b     <= nb(r_b, weff);
                    r_state <= S_WALK_WR;
                end
                S_WALK_WR: begin
                    if (({1'b0, r_p} + MOD_W'(r_k)) >= {1'b0, r_fos}) begin
                        r_total <= sat_sub32(r_total, r_rdata);
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == r_n) begin
                        r_state <= S_MOD;
                    end else begin
                        r_state <= S_WALK_RD;
                    end
                end
                S_MOD: begin
                    r_rem   <= rem_nxt;
                    r_mod_a <= {r_mod_a[MOD_W-2:0], 1'b0};
                    r_it    <= r_it + 1'b1;
                    if (r_it == IT_W'(MOD_W - 1)) begin
                        if (r_mod_scan) begin
                            r_b     <= rem_nxt[BKT_AW-1:0];
                            r_k     <= '0;
                            r_state <= S_SCAN_RD;
                        end else begin
                            r_cb    <= rem_nxt[BKT_AW-1:0];
                            r_state <= S_CUR_RD;
                        end
                    end
                end
                S_CUR_RD: begin
                    r_state <= S_CUR;
                end
                S_CUR: begin
                    r_total <= cur_total;
                    r_state <= S_JUDGE;
                end
                S_JUDGE: begin
                    if (sec >= SEC_W'(weff) && total_low) begin
                        if (r_last) begin
                            r_dl_time <= r_job.now_ticks + FINAL_GRACE;
                            r_dl_on   <= 1'b1;
                        end else begin
                            r_abort <= 1'b1;
                        end
                        r_state <= S_OUT;
                    end else if (!total_low) begin
                        r_d        <= MOD_W'(t0 - sec);
                        r_tot      <= r_total;
                        r_mod_a    <= ahead_arg(r_cb, MOD_W'(t0 - sec), weff);
                        r_rem      <= '0;
                        r_it       <= '0;
                        r_mod_scan <= 1'b1;
                        r_state    <= S_MOD;
                    end else begin
                        r_d     <= MOD_W'(weff - sec[WIN_W-1:0]);
                        r_state <= S_FIN;
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    r_tot <= tot_nxt;
                    if (tot_nxt < 32'(r_mint) || (r_k + 1'b1) >= weff) begin
                        r_state <= S_FIN;
                    end else begin
                        r_d     <= r_d + 1'b1;
                        r_b     <= nb(r_b, weff);
                        r_k     <= r_k + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_FIN: begin
                    r_dl_time <= r_job.now_ticks + d_ticks[31:0];
                    r_dl_on   <= 1'b1;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    r_out.abort_transfer    <= r_abort;
                    r_out.deadline_armed    <= r_dl_on;
                    r_out.stall_deadline    <= r_dl_on ? r_dl_time : 32'd0;
                    r_out.switched_to_reply <= r_switch;
                    r_out.sequence_error    <= r_seqerr;
                    r_out_valid             <= 1'b1;
                    r_state                 <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_WR) |-> (r_k != '0 && r_k <= r_n))
        else $error("bucket walk ran past its count");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (r_rem < weff))
        else $error("remainder left the window range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !r_out_valid)
        else $error("result written over an untaken result");

endmodule

>>> src/transfer_low_speed_watchdog.sv
`timescale 1ns / 1ps
// Timing: a phase request passes S_EXEC and S_OUT; a rate request passes S_MUL,
//   S_SEC and S_SAME on a repeated second, and on a later new second the bucket walk,
//   the bit-serial remainder unit, S_CUR, S_JUDGE (and a stall scan when one runs).
// Throughput: one request at a time in the engine; the remainder unit and the
//   one-port bucket memory walk (a read and a write state per bucket) set the rate.
// Reset: synchronous, active low; configuration returns to 60 s / 30 s / 7000 B/s.
// ============================================================================
// transfer_low_speed_watchdog
// Sliding-window low-speed detector for one transfer with deadline output.
// ============================================================================
module transfer_low_speed_watchdog
    import twd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    // request channel
    input  logic        i_req_valid,
    output logic        o_req_stall,
    input  t_req        i_req,
    // result channel
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output t_res        o_res
);

    // front -> queue
    logic q_push;
    t_job push_job;
    // queue -> engine
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_job head_job;

    // Front decodes the command; it stalls only when the queue is full.
    twd_front u_front (
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_req_stall (o_req_stall),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    // Two-entry queue decouples request intake from the engine.
    twd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Engine owns config, bucket memory and the result register.
    twd_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_job       (head_job),
        .i_q_empty   (q_empty),
        .o_pop       (q_pop),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res)
    );

endmodule

>>> verif/twd_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// twd_checker
// Watches the configuration port and both request/result channels of the
// watchdog, predicts each result from its own model of the window state and
// compares every accepted result field by field against the oldest prediction.
// ============================================================================
module twd_checker
    import twd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  t_req        i_req,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  t_res        i_res,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [31:0] SEC_IDLE = 32'h07FF_FFFF;

    // configuration copy
    logic [15:0] reply_secs;
    logic [6:0]  win_secs;
    logic [19:0] min_rate;

    // window state
    bit          rate_on;
    logic [31:0] win_start;
    logic [31:0] prev_sec;
    logic [31:0] overwrite_sec;
    logic [31:0] cur_bkt;
    logic [31:0] win_total;
    logic [31:0] bkt [MAX_WINDOW];
    logic [31:0] dl_time;
    bit          dl_on;
    bit          up_done;
    bit          redir_pending;
    bit          no_rx_yet;
    bit          last_sent;

    t_res expected_results[$];
    int   fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_results.size();

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sub_sat(logic [31:0] a, logic [31:0] b);
        return (a > b) ? a - b : 32'd0;
    endfunction

    function automatic logic [31:0] eff_win();
        if (win_secs == 0) return 32'd1;
        if (win_secs > MAX_WINDOW) return MAX_WINDOW;
        return {25'd0, win_secs};
    endfunction

    function automatic logic [31:0] step_bkt(logic [31:0] b, logic [31:0] w);
        return (b + 1 >= w) ? 32'd0 : b + 1;
    endfunction

    function automatic logic [31:0] bkt_ahead(logic [31:0] d, logic [31:0] w);
        if (d == 0) return cur_bkt;
        if (cur_bkt < w) return 32'(({32'd0, cur_bkt} + {32'd0, d}) % {32'd0, w});
        return (d - 1) % w;
    endfunction

    function automatic void restart_window(logic [31:0] now);
        win_start = now;
        rate_on   = 1;
        last_sent = 0;
        prev_sec  = SEC_IDLE;
        dl_on     = 0;
    endfunction

    function automatic void finish_upload(logic [31:0] now);
        if (up_done) return;
        up_done       = 1;
        redir_pending = 0;
        rate_on       = 0;
        dl_time       = now + 32'd100 * {16'd0, reply_secs};
        dl_on         = 1;
    endfunction

    // window update for one send/receive; returns the abort decision
    function automatic bit rate_update(logic [31:0] now, logic [31:0] nbytes, bit last);
        logic [31:0]     sec, w, p, gap, n, b, t0, d, tot;
        longint unsigned min_total;
        last_sent = last;
        sec = (now - win_start) / 32'd100;
        w   = eff_win();
        if (sec == prev_sec) begin
            win_total = add_sat(win_total, nbytes);
            if (cur_bkt < MAX_WINDOW) bkt[cur_bkt] = add_sat(bkt[cur_bkt], nbytes);
            return 0;
        end
        p = prev_sec;
        prev_sec = sec;
        if (p == SEC_IDLE) begin
            cur_bkt       = 0;
            overwrite_sec = sec + w;
            win_total     = nbytes;
            bkt[0]        = nbytes;
            return 0;
        end
        gap = (sec - p) & SEC_IDLE;
        n   = (gap - 1 < w) ? gap - 1 : w;
        b   = cur_bkt;
        for (int k = 1; k <= n; k++) begin
            b = step_bkt(b, w);
            if ({32'd0, p} + k >= {32'd0, overwrite_sec})
                win_total = sub_sat(win_total, bkt[b]);
            bkt[b] = 0;
        end
        cur_bkt = bkt_ahead(gap, w);
        if (sec >= overwrite_sec) win_total = sub_sat(win_total, bkt[cur_bkt]);
        win_total    = add_sat(win_total, nbytes);
        bkt[cur_bkt] = nbytes;

        min_total = longint'(min_rate) * longint'(w);
        if (sec >= w && win_total < min_total) begin
            if (last) begin
                dl_time = now + FINAL_GRACE;
                dl_on   = 1;
                return 0;
            end
            return 1;
        end
        if (win_total >= min_total) begin
            // earliest second at which zero-filled buckets drop the total too low
            t0  = (overwrite_sec > sec + 1) ? overwrite_sec : sec + 1;
            d   = t0 - sec;
            tot = win_total;
            b   = bkt_ahead(d, w);
            for (int k = 0; k < w; k++) begin
                tot = sub_sat(tot, bkt[b]);
                if (tot < min_total) break;
                if (k + 1 < w) begin
                    d++;
                    b = step_bkt(b, w);
                end
            end
            dl_time = now + 32'd100 * d;
        end else begin
            dl_time = now + 32'd100 * (w - sec);
        end
        dl_on = 1;
        return 0;
    endfunction

    function automatic t_res watchdog_step(t_req r);
        t_res res;
        res = '0;
        case (r.command)
            CMD_SENT: begin
                if (!rate_on) restart_window(r.now_ticks);
                res.abort_transfer = rate_update(r.now_ticks, {16'd0, r.byte_count},
                                                 r.last_bytes);
            end
            CMD_RECEIVED: begin
                if (no_rx_yet && r.byte_count != 0) begin
                    finish_upload(r.now_ticks);
                    no_rx_yet = 0;
                    restart_window(r.now_ticks);
                end
                if (rate_on)
                    res.abort_transfer = rate_update(r.now_ticks, {16'd0, r.byte_count}, 0);
            end
            CMD_UP_START: begin
                res.sequence_error = up_done && !redir_pending;
                up_done = 0;
                restart_window(r.now_ticks);
            end
            CMD_UP_DONE:  finish_upload(r.now_ticks);
            CMD_REDIRECT: redir_pending = 1;
            CMD_DONE: begin
                rate_on = 0;
                dl_on   = 0;
            end
            CMD_CHECK: begin
                if (!up_done && last_sent) begin
                    finish_upload(r.now_ticks);
                    res.switched_to_reply = 1;
                end
            end
            default: ;
        endcase
        res.deadline_armed = dl_on;
        res.stall_deadline = dl_on ? dl_time : 32'd0;
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: mismatch: %s", $time, what);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_res exp_res;
        if (!i_rst_n) begin
            reply_secs    <= 16'd60;
            win_secs      <= 7'd30;
            min_rate      <= 20'd7000;
            rate_on       <= 0;
            win_start     <= 0;
            prev_sec      <= SEC_IDLE;
            overwrite_sec <= 0;
            cur_bkt       <= 0;
            win_total     <= 0;
            dl_time       <= 0;
            dl_on         <= 0;
            up_done       <= 0;
            redir_pending <= 0;
            no_rx_yet     <= 1;
            last_sent     <= 0;
            for (int i = 0; i < MAX_WINDOW; i++) bkt[i] <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REPLY:  reply_secs = i_cfg_data[15:0];
                    CFG_WINDOW: win_secs   = i_cfg_data[6:0];
                    CFG_MIN:    min_rate   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && !i_req_stall)
                expected_results.push_back(watchdog_step(i_req));
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request pending");
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_res.abort_transfer !== exp_res.abort_transfer)
                        report_mismatch($sformatf("abort_transfer %b, expected %b",
                            i_res.abort_transfer, exp_res.abort_transfer));
                    if (i_res.deadline_armed !== exp_res.deadline_armed)
                        report_mismatch($sformatf("deadline_armed %b, expected %b",
                            i_res.deadline_armed, exp_res.deadline_armed));
                    if (i_res.stall_deadline !== exp_res.stall_deadline)
                        report_mismatch($sformatf("stall_deadline %h, expected %h",
                            i_res.stall_deadline, exp_res.stall_deadline));
                    if (i_res.switched_to_reply !== exp_res.switched_to_reply)
                        report_mismatch($sformatf("switched_to_reply %b, expected %b",
                            i_res.switched_to_reply, exp_res.switched_to_reply));
                    if (i_res.sequence_error !== exp_res.sequence_error)
                        report_mismatch($sformatf("sequence_error %b, expected %b",
                            i_res.sequence_error, exp_res.sequence_error));
                end
            end
        end
    end

    initial fails = 0;

endmodule

>>> verif/tb_transfer_low_speed_watchdog.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_transfer_low_speed_watchdog
// Drives directed and random request sequences through the watchdog under
// several window/rate/reply settings, with random stalls on both channels;
// the checker predicts and compares, this module gives the verdict.
// ============================================================================
module tb_transfer_low_speed_watchdog;
    import twd_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = CFG_REPLY;
    logic [19:0] cfg_data = '0;
    logic        req_valid = 0;
    logic        req_stall;
    t_req        req = '0;
    logic        res_valid;
    logic        res_stall = 0;
    t_res        res;

    int          fail_count;
    int          pending;

    // idling profile: 0 sender 38% / receiver 77%, 1 swapped, 2 none
    int          idle_mode = 0;
    int          sent_count = 0;
    bit          holdoff_done = 0;
    int          holdoff_left = 0;
    logic [31:0] clock_ticks;

    always #2 clk = ~clk;

    transfer_low_speed_watchdog dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_stall (res_stall),
        .o_res       (res)
    );

    twd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req        (req),
        .i_res_valid  (res_valid),
        .i_res_stall  (res_stall),
        .i_res        (res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side stall. One long hold-off after 100 requests lets the engine
    // back up until it stalls the request channel.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 0;
        end else if (!holdoff_done && sent_count >= 100) begin
            holdoff_done <= 1;
            holdoff_left <= 400;
            res_stall    <= 1;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            res_stall    <= 1;
        end else begin
            case (idle_mode)
                0: res_stall <= ($urandom_range(99) < 77);
                1: res_stall <= ($urandom_range(99) < 38);
                default: res_stall <= 0;
            endcase
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [19:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 0;
    endtask

    // Offer one request and hold it until accepted; then maybe idle.
    task automatic issue(logic [2:0] cmd, logic [31:0] now, logic [15:0] nbytes, bit last);
        int idle_pct;
        req_valid <= 1;
        req       <= '{command: cmd, now_ticks: now, byte_count: nbytes, last_bytes: last};
        do @(posedge clk); while (req_stall);
        sent_count++;
        idle_pct = (idle_mode == 0) ? 38 : (idle_mode == 1) ? 77 : 0;
        // one idle decision per cycle
        while ($urandom_range(99) < idle_pct) begin
            req_valid <= 0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Random request: mostly well-formed transfer traffic on a running clock,
    // with some noise (random time, unknown command) mixed in.
    task automatic random_request();
        int          pick;
        logic [15:0] nbytes;
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0: nbytes = 16'($urandom_range(0, 300));
            1: nbytes = 16'($urandom_range(0, 65535));
            default: nbytes = 16'($urandom_range(0, 9000));
        endcase
        if ($urandom_range(29) == 0)
            clock_ticks = clock_ticks + $urandom_range(3000, 20000);   // long gap
        else if ($urandom_range(59) == 0)
            clock_ticks = clock_ticks - $urandom_range(100, 5000);     // time goes back
        else
            clock_ticks = clock_ticks + $urandom_range(0, 150);
        if (pick < 8)
            issue(3'($urandom_range(7)), $urandom, 16'($urandom), 1'($urandom_range(1)));
        else if (pick < 13)
            issue(CMD_UP_START, clock_ticks, nbytes, 0);
        else if (pick < 55)
            issue(CMD_SENT, clock_ticks, nbytes, $urandom_range(7) == 0);
        else if (pick < 72)
            issue(CMD_RECEIVED, clock_ticks, nbytes, 1'($urandom_range(1)));
        else if (pick < 79)
            issue(CMD_UP_DONE, clock_ticks, nbytes, 0);
        else if (pick < 84)
            issue(CMD_REDIRECT, clock_ticks, nbytes, 0);
        else if (pick < 89)
            issue(CMD_DONE, clock_ticks, nbytes, 0);
        else
            issue(CMD_CHECK, clock_ticks, nbytes, 0);
    endtask

    // Watchdog on the run itself.
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [15:0] reply_set [6] = '{16'd0, 16'd65535, 16'd5, 16'd1, 16'd60, 16'd300};
        logic [6:0]  win_set   [6] = '{7'd1, 7'd64, 7'd3, 7'd0, 7'd8, 7'd100};
        logic [19:0] min_set   [6] = '{20'd1, 20'd1048575, 20'd500, 20'd0, 20'd7000, 20'd20000};
        int          rnd_idx;

        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Fill every bucket once: a 64 s window and a gap past it clears all.
        write_reg(CFG_WINDOW, 20'd64);
        issue(CMD_UP_START, 32'd0, 16'd0, 0);
        issue(CMD_SENT, 32'd0, 16'd65535, 0);
        issue(CMD_SENT, 32'd7000, 16'd0, 0);
        wait_drained();
        write_reg(CFG_WINDOW, 20'd30);

        // Directed: field extremes, every command, sequence cases.
        idle_mode = 2;
        issue(CMD_DONE, 32'd0, 16'd0, 0);
        issue(CMD_SENT, 32'hFFFF_FF00, 16'hFFFF, 0);      // clock wraps mid-window
        issue(CMD_SENT, 32'h0000_0100, 16'hFFFF, 0);
        issue(CMD_SENT, 32'h0000_0100, 16'hFFFF, 0);      // same second
        issue(CMD_SENT, 32'h0000_0050, 16'd1, 0);         // backwards in time
        issue(CMD_SENT, 32'h0000_0F00, 16'd0, 1);         // final bytes, rate low
        issue(CMD_CHECK, 32'h0000_0F10, 16'd0, 0);        // forces reply wait
        issue(CMD_CHECK, 32'h0000_0F20, 16'd0, 0);
        issue(CMD_UP_START, 32'h0000_1000, 16'd0, 0);     // after done: sequence error
        issue(CMD_UP_DONE, 32'h0000_1100, 16'd0, 0);
        issue(CMD_REDIRECT, 32'h0000_1200, 16'd0, 0);
        issue(CMD_UP_START, 32'h0000_1300, 16'd0, 0);     // after redirect: clean
        issue(CMD_SENT, 32'h0000_1300, 16'd40000, 0);
        issue(CMD_SENT, 32'h0000_1500, 16'd40000, 0);
        issue(CMD_SENT, 32'h0000_2400, 16'd100, 0);       // window full, rate low
        issue(CMD_RECEIVED, 32'h0000_2500, 16'd0, 0);
        issue(CMD_RECEIVED, 32'h0000_2600, 16'd5000, 0);  // first reply bytes
        issue(CMD_RECEIVED, 32'h0000_2700, 16'd5000, 1);
        issue(3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1);          // unknown command
        issue(CMD_DONE, 32'h0000_2800, 16'd0, 0);
        wait_drained();

        // Random phases, one per setting; idling profile moves by thirds.
        rnd_idx = 0;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_REPLY, {4'd0, reply_set[ph]});
            write_reg(CFG_WINDOW, {13'd0, win_set[ph]});
            write_reg(CFG_MIN, min_set[ph]);
            clock_ticks = (ph == 1) ? 32'hFFFF_E000 : $urandom;
            issue(CMD_UP_START, clock_ticks, 16'd0, 0);
            for (int i = 0; i < 140; i++) begin
                idle_mode = (rnd_idx < 280) ? 0 : (rnd_idx < 560) ? 1 : 2;
                random_request();
                rnd_idx++;
                // sender pause until the block has answered everything
                if (rnd_idx == 400) wait_drained();
            end
            wait_drained();
        end

        repeat (400) @(posedge clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/twd_pkg.sv
src/twd_front.sv
src/twd_queue.sv
src/twd_engine.sv
src/transfer_low_speed_watchdog.sv
verif/twd_checker.sv
verif/tb_transfer_low_speed_watchdog.sv
